[hw/rtl/mpfq_pkg.sv]
// ---------------------------------------------------------------------------
// mpfq_pkg
// Shared constants and types for the stable max-priority queue.
// ---------------------------------------------------------------------------
package mpfq_pkg;

    localparam int CAPACITY   = 16;
    localparam int TAG_BITS   = 32;

    localparam int PRIO_W     = 8;
    localparam int TAG_W      = 32;
    localparam int OCC_W      = 5;
    localparam int SLOT_TAG_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage

[hw/rtl/mpfq_if.sv]
// ---------------------------------------------------------------------------
// mpfq_req_if / mpfq_rsp_if
// Valid/ready channels for queue requests and their responses.
// ---------------------------------------------------------------------------
interface mpfq_req_if;
    import mpfq_pkg::*;

    logic                valid;
    logic                ready;
    t_kind               kind;
    logic [PRIO_W-1:0]   entry_priority;
    logic [TAG_W-1:0]    entry_tag;

    modport source (output valid, output kind, output entry_priority, output entry_tag,
                    input ready);
    modport sink   (input valid, input kind, input entry_priority, input entry_tag,
                    output ready);
endinterface

interface mpfq_rsp_if;
    import mpfq_pkg::*;

    logic                valid;
    logic                ready;
    t_status             status;
    logic [PRIO_W-1:0]   served_priority;
    logic [TAG_W-1:0]    served_tag;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output served_priority,
                    output served_tag, output occupancy, input ready);
    modport sink   (input valid, input status, input served_priority,
                    input served_tag, input occupancy, output ready);
endinterface

[hw/rtl/max_priority_fifo_queue_core.sv]
// ---------------------------------------------------------------------------
// max_priority_fifo_queue_core
// Bounded max-priority queue, ties served in arrival order.
//
// i_req carries one transaction per request: kind (insert or remove), plus
// priority and tag for an insert. o_rsp returns one transaction per request:
// status, the served priority and tag (zero unless served) and occupancy.
// Insert, remove on empty and insert on full answer directly: the
// response is registered at the accepting edge and is valid the next cycle.
// A remove with N entries held, best at slot b, walks the N slots with one
// comparator through the registered slot memory, then compacts the entries
// after slot b one slot per cycle, then loads its response once the output
// register is free. One request is in flight at a time; i_req.ready is low
// while a remove runs or while a held response cannot be replaced. A
// stalled o_rsp holds its transaction and also holds off new requests.
// Reset empties the queue and drops any pending response; slot contents
// are not cleared.
// ---------------------------------------------------------------------------
module max_priority_fifo_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpfq_req_if.sink    i_req,
    mpfq_rsp_if.source  o_rsp
);
    import mpfq_pkg::*;

    logic [PRIO_W-1:0]     r_mem_prio [CAPACITY];
    logic [SLOT_TAG_W-1:0] r_mem_tag  [CAPACITY];

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [PRIO_W-1:0]     r_rd_prio;
    logic [SLOT_TAG_W-1:0] r_rd_tag;
    logic                  r_cmp_v, r_cmp_first;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic [PRIO_W-1:0]     r_best_prio, n_best_prio;
    logic [SLOT_TAG_W-1:0] r_best_tag, n_best_tag;
    logic [IDX_W-1:0]      r_best_idx, n_best_idx;
    logic                  r_wr_pend;
    logic [IDX_W-1:0]      r_wr_addr;

    logic                  r_out_valid;
    t_status               r_out_status, n_out_status;
    logic [PRIO_W-1:0]     r_out_prio, n_out_prio;
    logic [TAG_W-1:0]      r_out_tag, n_out_tag;
    logic [OCC_W-1:0]      r_out_occ, n_out_occ;
    logic                  out_load;

    logic                  req_fire, out_free, is_full, is_empty;
    logic                  last_slot, shift_more, cmp_take, do_insert;
    logic [CNT_W-1:0]      idx_next;
    logic [IDX_W-1:0]      rd_addr;

    assign req_fire   = i_req.valid && i_req.ready;
    assign out_free   = !r_out_valid || o_rsp.ready;
    assign is_full    = (r_count == CNT_W'(CAPACITY));
    assign is_empty   = (r_count == '0);
    assign idx_next   = r_idx + 1'b1;
    assign last_slot  = (idx_next == r_count);
    assign shift_more = (idx_next < r_count);
    assign cmp_take   = r_cmp_v && (r_cmp_first || (r_rd_prio > r_best_prio));
    assign do_insert  = req_fire && (i_req.kind == KIND_INSERT) && !is_full;
    assign rd_addr    = (r_state == S_SHIFT) ? idx_next[IDX_W-1:0] : r_idx[IDX_W-1:0];

    assign i_req.ready          = (r_state == S_IDLE) && out_free;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.served_priority = r_out_prio;
    assign o_rsp.served_tag     = r_out_tag;
    assign o_rsp.occupancy      = r_out_occ;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire && (i_req.kind == KIND_REMOVE) && !is_empty) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_slot) begin
                    n_state = S_SCAN_LAST;
                end
            end
            S_SCAN_LAST: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (!shift_more) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath control and response
    always_comb begin
        n_best_prio  = cmp_take ? r_rd_prio : r_best_prio;
        n_best_tag   = cmp_take ? r_rd_tag  : r_best_tag;
        n_best_idx   = cmp_take ? r_cmp_idx : r_best_idx;
        n_idx        = r_idx;
        n_count      = r_count;
        out_load     = 1'b0;
        n_out_status = ST_INSERTED;
        n_out_prio   = '0;
        n_out_tag    = '0;
        n_out_occ    = '0;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (do_insert) begin
                    n_count = r_count + 1'b1;
                end
                if (req_fire) begin
                    if (i_req.kind == KIND_INSERT) begin
                        out_load     = 1'b1;
                        n_out_status = is_full ? ST_FULL : ST_INSERTED;
                    end else if (is_empty) begin
                        out_load     = 1'b1;
                        n_out_status = ST_EMPTY;
                    end
                end
            end
            S_SCAN: begin
                n_idx = idx_next;
            end
            S_SCAN_LAST: begin
                n_idx = CNT_W'(n_best_idx);
            end
            S_SHIFT: begin
                if (shift_more) begin
                    n_idx = idx_next;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_count      = r_count - 1'b1;
                    out_load     = 1'b1;
                    n_out_status = ST_SERVED;
                    n_out_prio   = r_best_prio;
                    n_out_tag    = TAG_W'(r_best_tag);
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
        n_out_occ = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_v     <= 1'b0;
            r_cmp_first <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_cmp_v     <= (r_state == S_SCAN);
            r_cmp_first <= (r_state == S_SCAN) && (r_idx == '0);
            r_wr_pend   <= (r_state == S_SHIFT) && shift_more;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx   <= r_idx[IDX_W-1:0];
        r_wr_addr   <= r_idx[IDX_W-1:0];
        r_best_prio <= n_best_prio;
        r_best_tag  <= n_best_tag;
        r_best_idx  <= n_best_idx;
        if (out_load) begin
            r_out_status <= n_out_status;
            r_out_prio   <= n_out_prio;
            r_out_tag    <= n_out_tag;
            r_out_occ    <= n_out_occ;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            r_mem_prio[r_count[IDX_W-1:0]] <= i_req.entry_priority;
            r_mem_tag[r_count[IDX_W-1:0]]  <= SLOT_TAG_W'(i_req.entry_tag);
        end else if (r_wr_pend) begin
            r_mem_prio[r_wr_addr] <= r_rd_prio;
            r_mem_tag[r_wr_addr]  <= r_rd_tag;
        end
        r_rd_prio <= r_mem_prio[rd_addr];
        r_rd_tag  <= r_mem_tag[rd_addr];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && (i_req.kind == KIND_INSERT) && !is_full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance occupancy");

    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !is_empty)
        else $error("remove in progress on an empty queue");

endmodule
